// File: rtl/core/selective_repeat_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// Selective repeat receiver assertion macros
// Concurrent assertion wrappers shared by the receiver RTL. Building with
// NO_ASSERTIONS defined turns every use into empty text.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Assertion that is switched off while reset is high.
`define SRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("srr assertion failed");

// Assertion that is checked in every cycle, reset included.
`define SRR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("srr assertion failed");

`else

`define SRR_ASSERT(lbl, clk, rst, prop)
`define SRR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/srr_pkg.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver package
// Shared constants, result codes and the payload word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

   // Packet geometry.
   localparam int PAYLOAD_BYTES = 20;
   localparam int SEQ_W         = 16;
   localparam int CHECK_W       = 32;

   // Checksum is formed from groups of bytes summed in parallel.
   localparam int SUM_GROUPS    = 4;
   localparam int GROUP_BYTES   = PAYLOAD_BYTES / SUM_GROUPS;
   localparam int GROUP_SUM_W   = 11;

   // Receive window register.
   localparam int          WIN_W        = 6;
   localparam logic [5:0]  WIN_RESET    = 6'd8;
   localparam logic [15:0] BASE_RESET   = 16'd1;

   // Default buffer depth handed to the top level.
   localparam int DEF_BUF_DEPTH = 64;

   // Result kinds.
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   // One stored payload, byte 0 in the lowest bits of lo.
   typedef struct packed {
      logic [31:0] hi;
      logic [63:0] mid;
      logic [63:0] lo;
   } payload_type;

endpackage

`default_nettype wire

// File: rtl/core/srr_channels.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver channels
// Valid/ready interfaces for the packet input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Incoming packet word.
interface srr_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        seq;
   logic [15:0]        ack_num;
   logic signed [31:0] check_value;
   logic [63:0]        payload_lo;
   logic [63:0]        payload_mid;
   logic [31:0]        payload_hi;

   modport source (output valid, seq, ack_num, check_value, payload_lo,
                   payload_mid, payload_hi, input ready);
   modport sink   (input valid, seq, ack_num, check_value, payload_lo,
                   payload_mid, payload_hi, output ready);
endinterface

// Outgoing result word: an acknowledgement or a delivery.
interface srr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] ack_seq;
   logic [63:0] out_lo;
   logic [63:0] out_mid;
   logic [31:0] out_hi;
   logic        last;

   modport source (output valid, kind, ack_seq, out_lo, out_mid, out_hi, last,
                   input ready);
   modport sink   (input valid, kind, ack_seq, out_lo, out_mid, out_hi, last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/core/srr_checksum.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver checksum
// Two-stage check: grouped byte sums, then the total against the carried value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srr_checksum (
   input  wire logic                clock,
   input  wire logic [15:0]         seq,
   input  wire logic [15:0]         ack_num,
   input  wire logic signed [31:0]  check_value,
   input  wire srr_pkg::payload_type payload,
   output logic                     match_ff
);
   import srr_pkg::*;

   localparam int BYTES_W = 8 * PAYLOAD_BYTES;

   logic [BYTES_W-1:0]     bytes;
   logic [GROUP_SUM_W-1:0] group_in [SUM_GROUPS];
   logic [GROUP_SUM_W-1:0] group_ff [SUM_GROUPS];
   logic [CHECK_W-1:0]     total;
   logic                   match_in;

   assign bytes = payload;

   // Stage one: each group adds its bytes sign-extended.
   always_comb begin
      for (int g = 0; g < SUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < GROUP_BYTES; b++) begin
            group_in[g] = group_in[g]
               + {{(GROUP_SUM_W-8){bytes[8*(g*GROUP_BYTES+b)+7]}},
                  bytes[8*(g*GROUP_BYTES+b) +: 8]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < SUM_GROUPS; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   // Stage two: group sums plus the two header numbers, compared in 32 bits.
   always_comb begin
      total = {16'd0, seq} + {16'd0, ack_num};
      for (int g = 0; g < SUM_GROUPS; g++) begin
         total = total + {{(CHECK_W-GROUP_SUM_W){group_ff[g][GROUP_SUM_W-1]}}, group_ff[g]};
      end
      match_in = (total == $unsigned(check_value));
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/srr_slot_store.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver slot store
// Payload memory with registered read, plus the held bit of every slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srr_slot_store #(
   parameter int BUF_DEPTH = srr_pkg::DEF_BUF_DEPTH,
   parameter int SLOT_W    = $clog2(BUF_DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [SLOT_W-1:0]    wr_addr,
   input  wire srr_pkg::payload_type wr_data,
   input  wire logic                 clr_en,
   input  wire logic [SLOT_W-1:0]    clr_addr,
   input  wire logic                 rd_en,
   input  wire logic [SLOT_W-1:0]    rd_addr,
   output srr_pkg::payload_type      rd_data_ff,
   output logic [BUF_DEPTH-1:0]      held_ff
);
   import srr_pkg::*;

   payload_type          mem_ff [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] held_in;

   // Payload memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Held bits are set on a store and cleared on a delivery.
   always_comb begin
      held_in = held_ff;
      if (wr_en) begin
         held_in[wr_addr] = 1'b1;
      end
      if (clr_en) begin
         held_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/selective_repeat_receiver_unit.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver unit
// Receiving side of selective repeat: checksum, window check, buffering and
// in-order delivery of the held run at the window base.
// ----------------------------------------------------------------------------
// Usage:
//   Packets enter on req_word; each is accepted only while the unit is idle.
//   Results leave on rsp_word: an acknowledgement first, then any deliveries
//   in sequence order; last marks the final result of a packet. A corrupt
//   packet or one ahead of the window causes no result.
//   csr_wr_en/csr_wr_data write the window size; write it only while idle.
// Sequence:
//   A packet passes checksum and window evaluation in ST_SUM, ST_CHK and
//   ST_EVAL; a dropped packet then frees the input, and otherwise ST_ACK
//   loads the acknowledgement into the output register. Each delivery then
//   adds one payload memory read (ST_RD) and one output load (ST_DLV).
// Reset:
//   Synchronous reset sets the window base to 1, the window size to 8 and
//   clears every held bit; the payload memory is not cleared.
// Stalls:
//   The output register holds a result until rsp_word.ready; the sequencer
//   waits on it, and the input is accepted again once the last result of the
//   current packet sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_receiver_unit_defines.svh"

module selective_repeat_receiver_unit #(
   parameter int BUF_DEPTH = srr_pkg::DEF_BUF_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   srr_req_if.sink                      req_word,
   srr_rsp_if.source                    rsp_word,
   input  wire logic                    csr_wr_en,
   input  wire logic [srr_pkg::WIN_W-1:0] csr_wr_data
);
   import srr_pkg::*;

   localparam int SLOT_W = $clog2(BUF_DEPTH);
   localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(BUF_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUF_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1 % BUF_DEPTH);
   localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W+1)'(BUF_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SUM  = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_EVAL = 7'b0001000,
      ST_ACK  = 7'b0010000,
      ST_RD   = 7'b0100000,
      ST_DLV  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [WIN_W-1:0]     win_ff;
   logic [WIN_W-1:0]     win_eff;
   logic [SEQ_W-1:0]     base_ff, base_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [WIN_W-1:0]     cnt_ff, cnt_in;
   logic [WIN_W-1:0]     cnt_inc;
   logic                 ack_only_ff, ack_only_in;

   logic [SEQ_W-1:0]     seq_ff;
   logic [SEQ_W-1:0]     ack_num_ff;
   logic signed [31:0]   check_ff;
   payload_type          pay_ff;

   logic                 req_take;
   logic                 sum_match;
   logic [SEQ_W-1:0]     seq_gap;
   logic                 is_behind;
   logic                 is_inside;
   logic [SLOT_W:0]      tgt_sum;
   logic [SLOT_W:0]      tgt_wrap;
   logic [SLOT_W-1:0]    slot_tgt;
   logic [SLOT_W-1:0]    slot_nxt;

   logic                 st_wr_en;
   logic                 st_clr_en;
   logic                 st_rd_en;
   payload_type          st_rd_data;
   logic [BUF_DEPTH-1:0] held;

   logic                 out_free;
   logic                 push;
   logic                 push_kind;
   logic [SEQ_W-1:0]     push_seq;
   payload_type          push_pay;
   logic                 push_last;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [SEQ_W-1:0]     rsp_seq_ff;
   payload_type          rsp_pay_ff;
   logic                 rsp_last_ff;

   // Input handshake and packet capture.
   assign req_word.ready = (state_ff == ST_IDLE);
   assign req_take       = req_word.valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_take) begin
         seq_ff     <= req_word.seq;
         ack_num_ff <= req_word.ack_num;
         check_ff   <= req_word.check_value;
         pay_ff     <= '{hi: req_word.payload_hi, mid: req_word.payload_mid,
                         lo: req_word.payload_lo};
      end
   end

   // Window size register and its clamped value.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_RESET;
      end else if (csr_wr_en) begin
         win_ff <= csr_wr_data;
      end
   end

   always_comb begin
      win_eff = win_ff;
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_MAX) begin
         win_eff = WIN_MAX;
      end
   end

   // Checksum pipeline, read in the evaluation state.
   srr_checksum u_checksum (
      .clock       (clock),
      .seq         (seq_ff),
      .ack_num     (ack_num_ff),
      .check_value (check_ff),
      .payload     (pay_ff),
      .match_ff    (sum_match)
   );

   // Window position and buffer slot of the packet.
   assign seq_gap   = seq_ff - base_ff;
   assign is_behind = seq_gap[SEQ_W-1];
   assign is_inside = !seq_gap[SEQ_W-1] && (seq_gap < {{(SEQ_W-WIN_W){1'b0}}, win_eff});
   assign tgt_sum   = {1'b0, slot_ff} + {1'b0, seq_gap[SLOT_W-1:0]};
   assign tgt_wrap  = (tgt_sum >= DEPTH_EXT) ? (tgt_sum - DEPTH_EXT) : tgt_sum;
   assign slot_tgt  = tgt_wrap[SLOT_W-1:0];
   assign slot_nxt  = (slot_ff == SLOT_LAST) ? '0 : (slot_ff + SLOT_W'(1));
   assign cnt_inc   = cnt_ff + WIN_W'(1);

   // The store is written in evaluation and read only in ST_RD, after the
   // acknowledgement, so a read never meets a write to the same slot in flight.
   srr_slot_store #(
      .BUF_DEPTH (BUF_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_slot_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (st_wr_en),
      .wr_addr    (slot_tgt),
      .wr_data    (pay_ff),
      .clr_en     (st_clr_en),
      .clr_addr   (slot_ff),
      .rd_en      (st_rd_en),
      .rd_addr    (slot_ff),
      .rd_data_ff (st_rd_data),
      .held_ff    (held)
   );

   assign out_free = !rsp_valid_ff || rsp_word.ready;

   // Sequencer: check, evaluate, acknowledge, then walk the held run.
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      ack_only_in = ack_only_ff;
      st_wr_en    = 1'b0;
      st_clr_en   = 1'b0;
      st_rd_en    = 1'b0;
      push        = 1'b0;
      push_kind   = KIND_ACK;
      push_seq    = seq_ff;
      push_pay    = '0;
      push_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!sum_match) begin
               state_in = ST_IDLE;
            end else if (is_behind) begin
               ack_only_in = 1'b1;
               state_in    = ST_ACK;
            end else if (is_inside) begin
               ack_only_in = 1'b0;
               st_wr_en    = !held[slot_tgt];
               state_in    = ST_ACK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = KIND_ACK;
               push_seq  = seq_ff;
               push_last = ack_only_ff || !held[slot_ff];
               cnt_in    = '0;
               state_in  = push_last ? ST_IDLE : ST_RD;
            end
         end
         ST_RD: begin
            st_rd_en = 1'b1;
            state_in = ST_DLV;
         end
         ST_DLV: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = KIND_DELIVER;
               push_seq  = base_ff;
               push_pay  = st_rd_data;
               push_last = (cnt_inc == win_eff) || !held[slot_nxt];
               st_clr_en = 1'b1;
               base_in   = base_ff + SEQ_W'(1);
               slot_in   = slot_nxt;
               cnt_in    = cnt_inc;
               state_in  = push_last ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         base_ff     <= BASE_RESET;
         slot_ff     <= SLOT_RESET;
         cnt_ff      <= '0;
         ack_only_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         base_ff     <= base_in;
         slot_ff     <= slot_in;
         cnt_ff      <= cnt_in;
         ack_only_ff <= ack_only_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_word.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_seq_ff  <= push_seq;
         rsp_pay_ff  <= push_pay;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_word.valid   = rsp_valid_ff;
   assign rsp_word.kind    = rsp_kind_ff;
   assign rsp_word.ack_seq = rsp_seq_ff;
   assign rsp_word.out_lo  = rsp_pay_ff.lo;
   assign rsp_word.out_mid = rsp_pay_ff.mid;
   assign rsp_word.out_hi  = rsp_pay_ff.hi;
   assign rsp_word.last    = rsp_last_ff;

   // A store never overwrites a payload that is still held.
   `SRR_ASSERT(a_store_free_slot, clock, reset, st_wr_en |-> !held[slot_tgt])
   // A delivery only reads a slot that is held.
   `SRR_ASSERT(a_dlv_held, clock, reset, (state_ff == ST_DLV) |-> held[slot_ff])
   // The delivery walk stays within the window.
   `SRR_ASSERT(a_walk_bound, clock, reset, (state_ff == ST_RD) |-> (cnt_ff < win_eff))
   // The base moves only with a delivery.
   `SRR_ASSERT(a_base_moves, clock, reset, !st_clr_en |=> $stable(base_ff))
   // The final result of a packet returns the sequencer to idle.
   `SRR_ASSERT(a_last_idle, clock, reset, (push && push_last) |=> (state_ff == ST_IDLE))

endmodule

`default_nettype wire
